// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl files, included by the encoder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/rvenc_pkg.sv -----
package rvenc_pkg;

    localparam int CMD_W   = 6;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 20;
    localparam int WORD_W  = 32;

    // mnemonic codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 6'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 6'd1;
    localparam logic [CMD_W-1:0] CMD_SLL   = 6'd2;
    localparam logic [CMD_W-1:0] CMD_SLT   = 6'd3;
    localparam logic [CMD_W-1:0] CMD_SLTU  = 6'd4;
    localparam logic [CMD_W-1:0] CMD_XOR   = 6'd5;
    localparam logic [CMD_W-1:0] CMD_SRL   = 6'd6;
    localparam logic [CMD_W-1:0] CMD_SRA   = 6'd7;
    localparam logic [CMD_W-1:0] CMD_OR    = 6'd8;
    localparam logic [CMD_W-1:0] CMD_AND   = 6'd9;
    localparam logic [CMD_W-1:0] CMD_JALR  = 6'd10;
    localparam logic [CMD_W-1:0] CMD_LB    = 6'd11;
    localparam logic [CMD_W-1:0] CMD_LH    = 6'd12;
    localparam logic [CMD_W-1:0] CMD_LW    = 6'd13;
    localparam logic [CMD_W-1:0] CMD_LBU   = 6'd14;
    localparam logic [CMD_W-1:0] CMD_LHU   = 6'd15;
    localparam logic [CMD_W-1:0] CMD_ADDI  = 6'd16;
    localparam logic [CMD_W-1:0] CMD_SLTI  = 6'd17;
    localparam logic [CMD_W-1:0] CMD_SLTIU = 6'd18;
    localparam logic [CMD_W-1:0] CMD_XORI  = 6'd19;
    localparam logic [CMD_W-1:0] CMD_ORI   = 6'd20;
    localparam logic [CMD_W-1:0] CMD_ANDI  = 6'd21;
    localparam logic [CMD_W-1:0] CMD_SLLI  = 6'd22;
    localparam logic [CMD_W-1:0] CMD_SRLI  = 6'd23;
    localparam logic [CMD_W-1:0] CMD_SRAI  = 6'd24;
    localparam logic [CMD_W-1:0] CMD_LUI   = 6'd25;
    localparam logic [CMD_W-1:0] CMD_AUIPC = 6'd26;
    localparam logic [CMD_W-1:0] CMD_JAL   = 6'd27;
    localparam logic [CMD_W-1:0] CMD_BEQ   = 6'd28;
    localparam logic [CMD_W-1:0] CMD_BNE   = 6'd29;
    localparam logic [CMD_W-1:0] CMD_BLT   = 6'd30;
    localparam logic [CMD_W-1:0] CMD_BGE   = 6'd31;
    localparam logic [CMD_W-1:0] CMD_BLTU  = 6'd32;
    localparam logic [CMD_W-1:0] CMD_BGEU  = 6'd33;
    localparam logic [CMD_W-1:0] CMD_SB    = 6'd34;
    localparam logic [CMD_W-1:0] CMD_SH    = 6'd35;
    localparam logic [CMD_W-1:0] CMD_SW    = 6'd36;

    // major opcodes
    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;

    typedef enum logic [2:0] {
        FMT_R,
        FMT_I,
        FMT_U,
        FMT_J,
        FMT_B,
        FMT_S
    } t_fmt;

    typedef struct packed {
        logic       known;
        t_fmt       fmt;
        logic [6:0] opcode;
        logic [2:0] funct3;
        logic [6:0] funct7;
        logic       imm_alt;    // srai: force immediate bit 10
    } t_desc;

endpackage

// ----- rtl/rvenc_decode.sv -----
module rvenc_decode (
    input  logic [rvenc_pkg::CMD_W-1:0] i_command,
    output rvenc_pkg::t_desc            o_desc
);
    import rvenc_pkg::*;

    function automatic t_desc f_mk(t_fmt fmt, logic [6:0] op, logic [2:0] f3,
                                   logic [6:0] f7, logic alt);
        t_desc d;
        d.known   = 1'b1;
        d.fmt     = fmt;
        d.opcode  = op;
        d.funct3  = f3;
        d.funct7  = f7;
        d.imm_alt = alt;
        return d;
    endfunction

    always_comb begin
        unique case (i_command)
            CMD_ADD:   o_desc = f_mk(FMT_R, OP_R, 3'd0, F7_BASE, 1'b0);
            CMD_SUB:   o_desc = f_mk(FMT_R, OP_R, 3'd0, F7_ALT, 1'b0);
            CMD_SLL:   o_desc = f_mk(FMT_R, OP_R, 3'd1, F7_BASE, 1'b0);
            CMD_SLT:   o_desc = f_mk(FMT_R, OP_R, 3'd2, F7_BASE, 1'b0);
            CMD_SLTU:  o_desc = f_mk(FMT_R, OP_R, 3'd3, F7_BASE, 1'b0);
            CMD_XOR:   o_desc = f_mk(FMT_R, OP_R, 3'd4, F7_BASE, 1'b0);
            CMD_SRL:   o_desc = f_mk(FMT_R, OP_R, 3'd5, F7_BASE, 1'b0);
            CMD_SRA:   o_desc = f_mk(FMT_R, OP_R, 3'd5, F7_ALT, 1'b0);
            CMD_OR:    o_desc = f_mk(FMT_R, OP_R, 3'd6, F7_BASE, 1'b0);
            CMD_AND:   o_desc = f_mk(FMT_R, OP_R, 3'd7, F7_BASE, 1'b0);
            CMD_JALR:  o_desc = f_mk(FMT_I, OP_JALR, 3'd0, F7_BASE, 1'b0);
            CMD_LB:    o_desc = f_mk(FMT_I, OP_LOAD, 3'd0, F7_BASE, 1'b0);
            CMD_LH:    o_desc = f_mk(FMT_I, OP_LOAD, 3'd1, F7_BASE, 1'b0);
            CMD_LW:    o_desc = f_mk(FMT_I, OP_LOAD, 3'd2, F7_BASE, 1'b0);
            CMD_LBU:   o_desc = f_mk(FMT_I, OP_LOAD, 3'd4, F7_BASE, 1'b0);
            CMD_LHU:   o_desc = f_mk(FMT_I, OP_LOAD, 3'd5, F7_BASE, 1'b0);
            CMD_ADDI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd0, F7_BASE, 1'b0);
            CMD_SLTI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd2, F7_BASE, 1'b0);
            CMD_SLTIU: o_desc = f_mk(FMT_I, OP_IMM, 3'd3, F7_BASE, 1'b0);
            CMD_XORI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd4, F7_BASE, 1'b0);
            CMD_ORI:   o_desc = f_mk(FMT_I, OP_IMM, 3'd6, F7_BASE, 1'b0);
            CMD_ANDI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd7, F7_BASE, 1'b0);
            CMD_SLLI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd1, F7_BASE, 1'b0);
            CMD_SRLI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd5, F7_BASE, 1'b0);
            CMD_SRAI:  o_desc = f_mk(FMT_I, OP_IMM, 3'd5, F7_BASE, 1'b1);
            CMD_LUI:   o_desc = f_mk(FMT_U, OP_LUI, 3'd0, F7_BASE, 1'b0);
            CMD_AUIPC: o_desc = f_mk(FMT_U, OP_AUIPC, 3'd0, F7_BASE, 1'b0);
            CMD_JAL:   o_desc = f_mk(FMT_J, OP_JAL, 3'd0, F7_BASE, 1'b0);
            CMD_BEQ:   o_desc = f_mk(FMT_B, OP_BRANCH, 3'd0, F7_BASE, 1'b0);
            CMD_BNE:   o_desc = f_mk(FMT_B, OP_BRANCH, 3'd1, F7_BASE, 1'b0);
            CMD_BLT:   o_desc = f_mk(FMT_B, OP_BRANCH, 3'd4, F7_BASE, 1'b0);
            CMD_BGE:   o_desc = f_mk(FMT_B, OP_BRANCH, 3'd5, F7_BASE, 1'b0);
            CMD_BLTU:  o_desc = f_mk(FMT_B, OP_BRANCH, 3'd6, F7_BASE, 1'b0);
            CMD_BGEU:  o_desc = f_mk(FMT_B, OP_BRANCH, 3'd7, F7_BASE, 1'b0);
            CMD_SB:    o_desc = f_mk(FMT_S, OP_STORE, 3'd0, F7_BASE, 1'b0);
            CMD_SH:    o_desc = f_mk(FMT_S, OP_STORE, 3'd1, F7_BASE, 1'b0);
            CMD_SW:    o_desc = f_mk(FMT_S, OP_STORE, 3'd2, F7_BASE, 1'b0);
            default: begin
                // codes past the last mnemonic encode to all zeros
                o_desc         = '0;
                o_desc.known   = 1'b0;
                o_desc.fmt     = FMT_R;
            end
        endcase
    end

endmodule

// ----- rtl/rvenc_pack.sv -----
module rvenc_pack (
    input  rvenc_pkg::t_desc             i_desc,
    input  logic [rvenc_pkg::REG_W-1:0]  i_reg_a,
    input  logic [rvenc_pkg::REG_W-1:0]  i_reg_b,
    input  logic [rvenc_pkg::REG_W-1:0]  i_reg_c,
    input  logic [rvenc_pkg::IMM_W-1:0]  i_imm,
    output logic [rvenc_pkg::WORD_W-1:0] o_word
);
    import rvenc_pkg::*;

    logic [11:0] imm12;

    assign imm12 = i_imm[11:0] | {1'b0, i_desc.imm_alt, 10'b0};

    always_comb begin
        if (!i_desc.known) begin
            o_word = '0;
        end else begin
            unique case (i_desc.fmt)
                FMT_R: o_word = {i_desc.funct7, i_reg_a, i_reg_b, i_desc.funct3,
                                 i_reg_c, i_desc.opcode};
                FMT_I: o_word = {imm12, i_reg_a, i_desc.funct3, i_reg_b, i_desc.opcode};
                FMT_U: o_word = {i_imm[19:0], i_reg_a, i_desc.opcode};
                // offsets arrive halved: imm bit n is offset bit n+1
                FMT_J: o_word = {i_imm[19], i_imm[9:0], i_imm[10], i_imm[18:11],
                                 i_reg_a, i_desc.opcode};
                FMT_B: o_word = {i_imm[11], i_imm[9:4], i_reg_a, i_reg_b, i_desc.funct3,
                                 i_imm[3:0], i_imm[10], i_desc.opcode};
                FMT_S: o_word = {i_imm[11:5], i_reg_a, i_reg_b, i_desc.funct3,
                                 i_imm[4:0], i_desc.opcode};
                default: o_word = '0;
            endcase
        end
    end

endmodule

// ----- rtl/rv32i_instruction_encoder_unit.sv -----
// RV32I instruction encoder
// input channel: i_valid / o_ready with i_command, i_reg_a, i_reg_b, i_reg_c,
//   i_immediate; a transaction is one parsed instruction
// output channel: o_valid / i_ready with o_instruction_word, one word per
//   input transaction, in order
// structure: input register, table decode plus bit placement, result register
// order: an input transaction is captured in the input register, then passes to the
//   result register, where it raises o_valid
// throughput: one instruction per cycle while i_ready does not stall the result register,
//   set by the single decode/pack path between the two registers
// stall: when o_valid is high and i_ready low the result register holds its word; the input
//   register still takes one more transaction, then o_ready drops until the
//   receiver drains
// reset: synchronous active-low i_rst_n empties both registers; o_valid is
//   low and o_ready high in the first cycle after reset
// unknown command codes give a zero word
`include "assert_macros.svh"

module rv32i_instruction_encoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rvenc_pkg::CMD_W-1:0]         i_command,
    input  logic [rvenc_pkg::REG_W-1:0]         i_reg_a,
    input  logic [rvenc_pkg::REG_W-1:0]         i_reg_b,
    input  logic [rvenc_pkg::REG_W-1:0]         i_reg_c,
    input  logic signed [rvenc_pkg::IMM_W-1:0]  i_immediate,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rvenc_pkg::WORD_W-1:0]        o_instruction_word
);
    import rvenc_pkg::*;

    logic               r_s1_valid;
    logic [CMD_W-1:0]   r_s1_cmd;
    logic [REG_W-1:0]   r_s1_reg_a;
    logic [REG_W-1:0]   r_s1_reg_b;
    logic [REG_W-1:0]   r_s1_reg_c;
    logic [IMM_W-1:0]   r_s1_imm;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;

    logic               out_ready;
    logic               s1_ready;
    logic               s1_advance;
    t_desc              desc;
    logic [WORD_W-1:0]  n_word;

    assign out_ready  = !r_out_valid || i_ready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign s1_advance = r_s1_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_cmd   <= i_command;
            r_s1_reg_a <= i_reg_a;
            r_s1_reg_b <= i_reg_b;
            r_s1_reg_c <= i_reg_c;
            r_s1_imm   <= i_immediate;
        end
    end

    rvenc_decode u_decode (
        .i_command (r_s1_cmd),
        .o_desc    (desc)
    );

    rvenc_pack u_pack (
        .i_desc  (desc),
        .i_reg_a (r_s1_reg_a),
        .i_reg_b (r_s1_reg_b),
        .i_reg_c (r_s1_reg_c),
        .i_imm   (r_s1_imm),
        .o_word  (n_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_word <= n_word;
        end
    end

    assign o_ready            = s1_ready;
    assign o_valid            = r_out_valid;
    assign o_instruction_word = r_out_word;

    // a held instruction must not be replaced while the result side is full
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !out_ready,
                 r_s1_valid && $stable(r_s1_cmd) && $stable(r_s1_imm))
    // an instruction moving out of the input register lands in the result register
    `ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s1_advance, r_out_valid)
    // unknown codes encode to zero
    `ASSERT_IMPL(a_unknown_zero, i_clk, i_rst_n, r_s1_valid && !desc.known,
                 n_word == '0)
    // every known encoding ends in the 32-bit marker
    `ASSERT_IMPL(a_low_bits, i_clk, i_rst_n, r_s1_valid && desc.known,
                 n_word[1:0] == 2'b11)
    // an empty input register always takes a transaction
    `ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !r_s1_valid, o_ready)

endmodule
